>>> sv/brr_pkg.sv
package brr_pkg;

    localparam int DEPTH   = 1024;
    localparam int MAX_RUN = 64;

    localparam int FUNC_W = 3;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int STAT_W = 2;
    localparam int FILL_W = 11;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    // common width for length, count and pointer sums, one bit of headroom
    localparam int CMP_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

    localparam logic [FUNC_W-1:0] FN_APPEND = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FN_GET    = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FN_PEEK   = FUNC_W'(2);
    localparam logic [FUNC_W-1:0] FN_SKIP   = FUNC_W'(3);
    localparam logic [FUNC_W-1:0] FN_CLEAR  = FUNC_W'(4);

    localparam logic [STAT_W-1:0] STAT_OK     = STAT_W'(0);
    localparam logic [STAT_W-1:0] STAT_BADLEN = STAT_W'(1);
    localparam logic [STAT_W-1:0] STAT_FULL   = STAT_W'(2);
    localparam logic [STAT_W-1:0] STAT_NODATA = STAT_W'(3);

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  run_len;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_byte;
        logic [STAT_W-1:0] status;
        logic              last;
        logic [FILL_W-1:0] fill_level;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RESULT,
        S_RD_ISSUE,
        S_RD_EMIT
    } ctrl_state_t;

    // ring pointer advance with wrap at DEPTH, inc never above DEPTH
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] pos,
                                                  input logic [CMP_W-1:0] inc);
        logic [CMP_W-1:0] sum;
        sum = CMP_W'(pos) + inc;
        if (sum >= CMP_W'(DEPTH))
        begin
            sum = sum - CMP_W'(DEPTH);
        end
        return PTR_W'(sum);
    endfunction

endpackage

>>> sv/brr_ram.sv
module brr_ram #(
    parameter int DEPTH_P = 1024,
    parameter int WIDTH_P = 8,
    localparam int ADDR_W = $clog2(DEPTH_P)
) (
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [WIDTH_P-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [WIDTH_P-1:0] rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/brr_ctrl.sv
module brr_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  brr_pkg::req_t                    req,
    input  logic                             res_free,
    output logic                             res_push,
    output brr_pkg::rsp_t                    res_item,
    output logic                             ram_we,
    output logic [brr_pkg::PTR_W-1:0]        ram_waddr,
    output logic [brr_pkg::BYTE_W-1:0]       ram_wdata,
    output logic                             ram_re,
    output logic [brr_pkg::PTR_W-1:0]        ram_raddr,
    input  logic [brr_pkg::BYTE_W-1:0]       ram_rdata
);

    brr_pkg::ctrl_state_t               state_reg, state_next;
    brr_pkg::req_t                      item_reg, item_next;
    logic [brr_pkg::PTR_W-1:0]          rd_pos_reg, rd_pos_next;
    logic [brr_pkg::PTR_W-1:0]          wr_pos_reg, wr_pos_next;
    logic [brr_pkg::PTR_W-1:0]          ptr_reg, ptr_next;
    logic [brr_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [brr_pkg::LEN_W-1:0]          left_reg, left_next;
    logic [brr_pkg::LEN_W-1:0]          idx_reg, idx_next;
    logic                               refused_reg, refused_next;
    logic [brr_pkg::STAT_W-1:0]         code_reg, code_next;
    logic [brr_pkg::STAT_W-1:0]         res_status_reg, res_status_next;

    logic [brr_pkg::CMP_W-1:0]          len_c, cnt_c;
    logic                               len_zero, app_len_bad, app_full, rd_len_bad;
    logic                               app_refused, app_store, rd_ok;
    logic [brr_pkg::STAT_W-1:0]         app_code;
    logic [brr_pkg::LEN_W-1:0]          app_left;

    // length and space checks
    assign len_c    = brr_pkg::CMP_W'(item_reg.run_len);
    assign cnt_c    = brr_pkg::CMP_W'(count_reg);
    assign len_zero = (item_reg.run_len == '0);
    assign app_len_bad = len_zero || (len_c > brr_pkg::CMP_W'(brr_pkg::MAX_RUN))
                         || (len_c > brr_pkg::CMP_W'(brr_pkg::DEPTH));
    assign app_full    = (cnt_c + len_c) > brr_pkg::CMP_W'(brr_pkg::DEPTH);
    assign rd_len_bad  = len_zero || (len_c > brr_pkg::CMP_W'(brr_pkg::MAX_RUN))
                         || (len_c > cnt_c);
    assign rd_ok       = (count_reg != '0) && !rd_len_bad;

    // run bookkeeping: first byte of a run decides for the whole run
    always_comb
    begin
        if (left_reg == '0)
        begin
            app_refused = app_len_bad || app_full;
            app_code    = app_len_bad ? brr_pkg::STAT_BADLEN :
                          (app_full ? brr_pkg::STAT_FULL : brr_pkg::STAT_OK);
            app_left    = len_zero ? brr_pkg::LEN_W'(1) : item_reg.run_len;
        end
        else
        begin
            app_refused = refused_reg;
            app_code    = code_reg;
            app_left    = left_reg;
        end
    end

    assign app_store = !app_refused && (cnt_c < brr_pkg::CMP_W'(brr_pkg::DEPTH));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            brr_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = brr_pkg::S_EXEC;
                end
            end
            brr_pkg::S_EXEC:
            begin
                unique case (item_reg.func)
                    brr_pkg::FN_APPEND:
                        state_next = (app_left == brr_pkg::LEN_W'(1)) ? brr_pkg::S_RESULT
                                                                     : brr_pkg::S_IDLE;
                    brr_pkg::FN_GET, brr_pkg::FN_PEEK:
                        state_next = rd_ok ? brr_pkg::S_RD_ISSUE : brr_pkg::S_RESULT;
                    brr_pkg::FN_SKIP, brr_pkg::FN_CLEAR:
                        state_next = brr_pkg::S_RESULT;
                    default:
                        state_next = brr_pkg::S_IDLE;
                endcase
            end
            brr_pkg::S_RESULT:
            begin
                if (res_free)
                begin
                    state_next = brr_pkg::S_IDLE;
                end
            end
            brr_pkg::S_RD_ISSUE:
            begin
                state_next = brr_pkg::S_RD_EMIT;
            end
            brr_pkg::S_RD_EMIT:
            begin
                if (res_free)
                begin
                    state_next = (idx_reg == brr_pkg::LEN_W'(1)) ? brr_pkg::S_IDLE
                                                                : brr_pkg::S_RD_ISSUE;
                end
            end
            default:
            begin
                state_next = brr_pkg::S_IDLE;
            end
        endcase
    end

    // datapath updates
    always_comb
    begin
        item_next       = item_reg;
        rd_pos_next     = rd_pos_reg;
        wr_pos_next     = wr_pos_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        left_next       = left_reg;
        idx_next        = idx_reg;
        refused_next    = refused_reg;
        code_next       = code_reg;
        res_status_next = res_status_reg;
        unique case (state_reg)
            brr_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                end
            end
            brr_pkg::S_EXEC:
            begin
                unique case (item_reg.func)
                    brr_pkg::FN_APPEND:
                    begin
                        if (app_store)
                        begin
                            wr_pos_next = brr_pkg::wrap_add(wr_pos_reg, brr_pkg::CMP_W'(1));
                            count_next  = count_reg + brr_pkg::CNT_W'(1);
                        end
                        left_next = app_left - brr_pkg::LEN_W'(1);
                        if (app_left == brr_pkg::LEN_W'(1))
                        begin
                            refused_next    = 1'b0;
                            code_next       = brr_pkg::STAT_OK;
                            res_status_next = app_refused ? app_code : brr_pkg::STAT_OK;
                        end
                        else
                        begin
                            refused_next = app_refused;
                            code_next    = app_code;
                        end
                    end
                    brr_pkg::FN_GET, brr_pkg::FN_PEEK, brr_pkg::FN_SKIP:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = brr_pkg::STAT_NODATA;
                        end
                        else if (rd_len_bad)
                        begin
                            res_status_next = brr_pkg::STAT_BADLEN;
                        end
                        else
                        begin
                            res_status_next = brr_pkg::STAT_OK;
                            ptr_next        = rd_pos_reg;
                            idx_next        = item_reg.run_len;
                            if (item_reg.func != brr_pkg::FN_PEEK)
                            begin
                                rd_pos_next = brr_pkg::wrap_add(rd_pos_reg, len_c);
                                count_next  = count_reg - brr_pkg::CNT_W'(item_reg.run_len);
                            end
                        end
                    end
                    brr_pkg::FN_CLEAR:
                    begin
                        rd_pos_next     = '0;
                        wr_pos_next     = '0;
                        count_next      = '0;
                        left_next       = '0;
                        refused_next    = 1'b0;
                        code_next       = brr_pkg::STAT_OK;
                        res_status_next = brr_pkg::STAT_OK;
                    end
                    default:
                    begin
                    end
                endcase
            end
            brr_pkg::S_RD_ISSUE:
            begin
                ptr_next = brr_pkg::wrap_add(ptr_reg, brr_pkg::CMP_W'(1));
            end
            brr_pkg::S_RD_EMIT:
            begin
                if (res_free)
                begin
                    idx_next = idx_reg - brr_pkg::LEN_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready = (state_reg == brr_pkg::S_IDLE);
        res_push  = res_free && ((state_reg == brr_pkg::S_RESULT)
                                 || (state_reg == brr_pkg::S_RD_EMIT));
        ram_we    = (state_reg == brr_pkg::S_EXEC) && (item_reg.func == brr_pkg::FN_APPEND)
                    && app_store;
        ram_waddr = wr_pos_reg;
        ram_wdata = item_reg.data_byte;
        ram_re    = (state_reg == brr_pkg::S_RD_ISSUE);
        ram_raddr = ptr_reg;
        res_item.fill_level = brr_pkg::FILL_W'(count_reg);
        if (state_reg == brr_pkg::S_RD_EMIT)
        begin
            res_item.out_byte = ram_rdata;
            res_item.has_byte = 1'b1;
            res_item.status   = brr_pkg::STAT_OK;
            res_item.last     = (idx_reg == brr_pkg::LEN_W'(1));
        end
        else
        begin
            res_item.out_byte = '0;
            res_item.has_byte = 1'b0;
            res_item.status   = res_status_reg;
            res_item.last     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= brr_pkg::S_IDLE;
            rd_pos_reg  <= '0;
            wr_pos_reg  <= '0;
            count_reg   <= '0;
            left_reg    <= '0;
            refused_reg <= 1'b0;
            code_reg    <= brr_pkg::STAT_OK;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pos_reg  <= rd_pos_next;
            wr_pos_reg  <= wr_pos_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            refused_reg <= refused_next;
            code_reg    <= code_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        ptr_reg        <= ptr_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= brr_pkg::CNT_W'(brr_pkg::DEPTH))
        else $error("stored count above depth");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        brr_pkg::wrap_add(rd_pos_reg, brr_pkg::CMP_W'(count_reg)) == wr_pos_reg)
        else $error("pointers disagree with stored count");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == brr_pkg::S_EXEC)
        else $error("accepted item not executed");

    a_emit_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == brr_pkg::S_RD_EMIT |-> idx_reg != '0)
        else $error("byte emitted with no bytes left");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> res_free)
        else $error("result pushed into a full output stage");

endmodule

>>> sv/byte_ring_buffer_runs_top.sv
// circular byte fifo with all-or-nothing append and read runs
//
// req channel (req_valid/req_ready/req): one transfer per command; func selects
//   append byte, get run, peek run, skip run or clear. an append run is a
//   series of append transfers, the first one giving the run length
// rsp channel (rsp_valid/rsp_ready/rsp): results; a get or peek of n bytes
//   gives n transfers with has_byte set, last on the final one; an append run
//   gives a single status transfer on its final byte; skip and clear one;
//   unused func codes none; a refused get or peek gives one status transfer
// operation: a sequencer runs one command at a time over the shared byte ram
//   (one write and one registered read port); req_ready is high only when idle
//   append byte without result or unused code: idle, then exec
//   final append byte, skip, clear, refused read: idle, exec, then a result
//   state that pushes the result into the output register once it is free
//   get/peek of n bytes: idle, exec, then one ram read plus one emit per byte
// reset: pointers, fill count and append state clear at once; ram contents
//   are not cleared and no clearing pass runs
// stall: results sit in one output register; while rsp_ready is low and that
//   register is full the sequencer holds at its next result and takes no new
//   command until that result has moved into the register
module byte_ring_buffer_runs_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  brr_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output brr_pkg::rsp_t rsp
);

    logic                         res_free;
    logic                         res_push;
    brr_pkg::rsp_t                res_item;
    logic                         ram_we;
    logic [brr_pkg::PTR_W-1:0]    ram_waddr;
    logic [brr_pkg::BYTE_W-1:0]   ram_wdata;
    logic                         ram_re;
    logic [brr_pkg::PTR_W-1:0]    ram_raddr;
    logic [brr_pkg::BYTE_W-1:0]   ram_rdata;

    logic                         rsp_valid_reg, rsp_valid_next;
    brr_pkg::rsp_t                rsp_reg;

    // command sequencer with pointers, fill count and run state
    brr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_free  (res_free),
        .res_push  (res_push),
        .res_item  (res_item),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // byte storage for the ring
    brr_ram #(
        .DEPTH_P (brr_pkg::DEPTH),
        .WIDTH_P (brr_pkg::BYTE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register: free when empty or being taken this cycle
    assign res_free       = !rsp_valid_reg || rsp_ready;
    assign rsp_valid_next = res_push || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            rsp_reg <= res_item;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> sim/tb_byte_ring_buffer_runs_top.sv
module tb_byte_ring_buffer_runs_top;

    timeunit 1ns;
    timeprecision 1ps;

    // command codes the block ignores
    localparam logic [brr_pkg::FUNC_W-1:0] FN_SPARE_LO = brr_pkg::FN_CLEAR + 1'b1;
    localparam logic [brr_pkg::FUNC_W-1:0] FN_SPARE_HI = '1;

    localparam int LEN_MAX      = (1 << brr_pkg::LEN_W) - 1;
    localparam int RAND_ITEMS   = 350;
    // room for the longest get of 64 bytes, plus room for a late stray result
    localparam int END_IDLE     = 200;
    localparam int LIMIT_CYCLES = 3_000_000;

    // ------------------------------------------------------------------
    // ring mirror: keeps its own copy of the fifo and the append run
    // state, turns every accepted command into the results it must cause
    // and checks the result stream against them in order
    // ------------------------------------------------------------------
    class byte_ring_tracker;
        logic [brr_pkg::BYTE_W-1:0] mirror_mem [brr_pkg::DEPTH];
        logic [brr_pkg::PTR_W-1:0]  rd_ptr;
        logic [brr_pkg::PTR_W-1:0]  wr_ptr;
        logic [brr_pkg::CNT_W-1:0]  fill;
        logic [brr_pkg::LEN_W-1:0]  run_left;
        logic                       run_dropped;
        logic [brr_pkg::STAT_W-1:0] run_status;
        brr_pkg::rsp_t              pending_rsp[$];
        int                         mismatches;
        int                         checked;
        int                         bytes_seen;
        int                         status_hits [4];

        function new();
            rd_ptr      = '0;
            wr_ptr      = '0;
            fill        = '0;
            run_left    = '0;
            run_dropped = 1'b0;
            run_status  = brr_pkg::STAT_OK;
            mismatches  = 0;
            checked     = 0;
            bytes_seen  = 0;
            foreach (status_hits[i])
            begin
                status_hits[i] = 0;
            end
        endfunction

        function logic [brr_pkg::PTR_W-1:0] next_slot(logic [brr_pkg::PTR_W-1:0] p);
            return (p == brr_pkg::PTR_W'(brr_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
        endfunction

        // fill_level always reflects the state after the command
        function void expect_rsp(logic [brr_pkg::BYTE_W-1:0] b, logic has,
                                 logic [brr_pkg::STAT_W-1:0] st, logic lst);
            brr_pkg::rsp_t r;
            r.out_byte   = b;
            r.has_byte   = has;
            r.status     = st;
            r.last       = lst;
            r.fill_level = brr_pkg::FILL_W'(fill);
            pending_rsp.push_back(r);
            status_hits[st]++;
        endfunction

        function void take_command(brr_pkg::req_t c);
            logic [brr_pkg::PTR_W-1:0] p;
            int                        n;
            n = c.run_len;
            case (c.func)
                brr_pkg::FN_APPEND:
                begin
                    // first byte of a run decides the fate of the whole run
                    if (run_left == '0)
                    begin
                        run_left    = (n == 0) ? brr_pkg::LEN_W'(1) : c.run_len;
                        run_dropped = 1'b0;
                        run_status  = brr_pkg::STAT_OK;
                        if (n == 0 || n > brr_pkg::MAX_RUN || n > brr_pkg::DEPTH)
                        begin
                            run_dropped = 1'b1;
                            run_status  = brr_pkg::STAT_BADLEN;
                        end
                        else if (brr_pkg::DEPTH - int'(fill) < n)
                        begin
                            run_dropped = 1'b1;
                            run_status  = brr_pkg::STAT_FULL;
                        end
                    end
                    if (!run_dropped && int'(fill) < brr_pkg::DEPTH)
                    begin
                        mirror_mem[wr_ptr] = c.data_byte;
                        wr_ptr             = next_slot(wr_ptr);
                        fill               = fill + 1'b1;
                    end
                    run_left = run_left - 1'b1;
                    if (run_left == '0)
                    begin
                        expect_rsp('0, 1'b0, run_dropped ? run_status : brr_pkg::STAT_OK,
                                   1'b1);
                        run_dropped = 1'b0;
                        run_status  = brr_pkg::STAT_OK;
                    end
                end
                brr_pkg::FN_GET, brr_pkg::FN_PEEK, brr_pkg::FN_SKIP:
                begin
                    if (fill == '0)
                    begin
                        expect_rsp('0, 1'b0, brr_pkg::STAT_NODATA, 1'b1);
                    end
                    else if (n == 0 || n > brr_pkg::MAX_RUN || n > int'(fill))
                    begin
                        expect_rsp('0, 1'b0, brr_pkg::STAT_BADLEN, 1'b1);
                    end
                    else
                    begin
                        p = rd_ptr;
                        if (c.func != brr_pkg::FN_PEEK)
                        begin
                            repeat (n) rd_ptr = next_slot(rd_ptr);
                            fill = fill - brr_pkg::CNT_W'(n);
                        end
                        if (c.func == brr_pkg::FN_SKIP)
                        begin
                            expect_rsp('0, 1'b0, brr_pkg::STAT_OK, 1'b1);
                        end
                        else
                        begin
                            for (int i = 0; i < n; i++)
                            begin
                                expect_rsp(mirror_mem[p], 1'b1, brr_pkg::STAT_OK, i == n - 1);
                                p = next_slot(p);
                            end
                        end
                    end
                end
                brr_pkg::FN_CLEAR:
                begin
                    rd_ptr      = '0;
                    wr_ptr      = '0;
                    fill        = '0;
                    run_left    = '0;
                    run_dropped = 1'b0;
                    run_status  = brr_pkg::STAT_OK;
                    expect_rsp('0, 1'b0, brr_pkg::STAT_OK, 1'b1);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void match_result(brr_pkg::rsp_t got);
            brr_pkg::rsp_t want;
            string         diff;
            checked++;
            if (got.has_byte)
            begin
                bytes_seen++;
            end
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none got %02h/%0b/%0d/%0b/%0d",
                         $time, got.out_byte, got.has_byte, got.status, got.last,
                         got.fill_level);
                return;
            end
            want = pending_rsp.pop_front();
            diff = "";
            if (got.out_byte !== want.out_byte)
            begin
                diff = {diff, " out_byte"};
            end
            if (got.has_byte !== want.has_byte)
            begin
                diff = {diff, " has_byte"};
            end
            if (got.status !== want.status)
            begin
                diff = {diff, " status"};
            end
            if (got.last !== want.last)
            begin
                diff = {diff, " last"};
            end
            if (got.fill_level !== want.fill_level)
            begin
                diff = {diff, " fill_level"};
            end
            if (diff != "")
            begin
                mismatches++;
                $display("%0t:%s differ, expected %02h/%0b/%0d/%0b/%0d got %02h/%0b/%0d/%0b/%0d",
                         $time, diff, want.out_byte, want.has_byte, want.status, want.last,
                         want.fill_level, got.out_byte, got.has_byte, got.status, got.last,
                         got.fill_level);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // dut hookup, every input known from time zero
    // ------------------------------------------------------------------
    logic          clk;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    brr_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    brr_pkg::rsp_t rsp;

    byte_ring_tracker tracker = new();

    int          commands_sent = 0;   // ignored spare codes left out
    int          req_quiet     = 0;   // transfers left in a no-gap stretch
    int          rsp_quiet     = 0;
    int unsigned cycle_count   = 0;

    byte_ring_buffer_runs_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // gap drawing: mostly a random idle gap before each transfer, now and then a
    // stretch of back-to-back transfers
    // ------------------------------------------------------------------
    task automatic draw_gap(inout int quiet, output int gap);
        if (quiet > 0)
        begin
            quiet--;
            gap = 0;
        end
        else if ($urandom_range(0, 24) == 0)
        begin
            quiet = $urandom_range(10, 40);
            gap   = 0;
        end
        else
        begin
            gap = $urandom_range(0, 19);
        end
    endtask

    // one command transfer; valid stays up across back-to-back transfers
    // so it is never dropped and raised in the same step
    task automatic send_cmd(input logic [brr_pkg::FUNC_W-1:0] f,
                            input logic [brr_pkg::BYTE_W-1:0] b,
                            input logic [brr_pkg::LEN_W-1:0] n);
        brr_pkg::req_t c;
        int            gap;
        c.func      = f;
        c.data_byte = b;
        c.run_len   = n;
        draw_gap(req_quiet, gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= c;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        tracker.take_command(c);
        if (f <= brr_pkg::FN_CLEAR)
        begin
            commands_sent++;
        end
    endtask

    // get, peek or skip; length mostly legal, sometimes right at or past
    // the fill level, zero, or beyond the longest run
    task automatic random_read();
        logic [brr_pkg::FUNC_W-1:0] f;
        int                         n;
        int                         top;
        case ($urandom_range(0, 2))
            0:       f = brr_pkg::FN_GET;
            1:       f = brr_pkg::FN_PEEK;
            default: f = brr_pkg::FN_SKIP;
        endcase
        top = (int'(tracker.fill) < brr_pkg::MAX_RUN) ? int'(tracker.fill) : brr_pkg::MAX_RUN;
        case ($urandom_range(0, 9))
            0:       n = top + 1;
            1:       n = ($urandom_range(0, 1) == 0) ? 0
                         : $urandom_range(brr_pkg::MAX_RUN + 1, LEN_MAX);
            2:       n = top;
            default: n = (top == 0) ? $urandom_range(0, LEN_MAX) : $urandom_range(1, top);
        endcase
        send_cmd(f, brr_pkg::BYTE_W'($urandom), brr_pkg::LEN_W'(n));
    endtask

    // append run of n bytes (one byte for a zero length); reads slip in
    // now and then; with cut > 0 the run is abandoned by a clear
    task automatic append_run(input int n, input int cut);
        int total;
        total = (n == 0) ? 1 : n;
        for (int k = 0; k < total; k++)
        begin
            if (cut > 0 && k == cut)
            begin
                send_cmd(brr_pkg::FN_CLEAR, brr_pkg::BYTE_W'($urandom),
                         brr_pkg::LEN_W'($urandom));
                return;
            end
            if (k > 0 && $urandom_range(0, 19) == 0)
            begin
                random_read();
            end
            // length field on later bytes is noise the block must ignore
            send_cmd(brr_pkg::FN_APPEND, brr_pkg::BYTE_W'($urandom),
                     (k == 0) ? brr_pkg::LEN_W'(n) : brr_pkg::LEN_W'($urandom));
        end
    endtask

    // one random sequence; filling leans on appends, draining on reads,
    // clears and broken runs
    task automatic random_step(input bit filling);
        int r;
        int n;
        int room;
        r    = $urandom_range(0, 99);
        room = brr_pkg::DEPTH - int'(tracker.fill);
        if (r < (filling ? 75 : 30))
        begin
            // near the top aim at exact fill or one byte too many
            if (room <= brr_pkg::MAX_RUN && $urandom_range(0, 9) < 7)
            begin
                if (room > 0 && $urandom_range(0, 1) == 0)
                begin
                    n = room;
                end
                else
                begin
                    n = (room < brr_pkg::MAX_RUN) ? room + 1
                        : $urandom_range(1, brr_pkg::MAX_RUN);
                end
            end
            else
            begin
                n = $urandom_range(1, brr_pkg::MAX_RUN);
            end
            append_run(n, 0);
        end
        else if (r < (filling ? 96 : 85))
        begin
            random_read();
        end
        else if (r < (filling ? 99 : 89))
        begin
            // invalid length: zero, or a long run dropped byte by byte
            n = ($urandom_range(0, 2) == 0)
                ? int'($urandom_range(brr_pkg::MAX_RUN + 1, LEN_MAX)) : 0;
            append_run(n, 0);
        end
        else if (!filling && r < 94)
        begin
            n = $urandom_range(2, brr_pkg::MAX_RUN);
            append_run(n, $urandom_range(1, n - 1));
        end
        else if (!filling && r < 97)
        begin
            send_cmd(brr_pkg::FN_CLEAR, brr_pkg::BYTE_W'($urandom),
                     brr_pkg::LEN_W'($urandom));
        end
        else
        begin
            send_cmd(brr_pkg::FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)),
                     brr_pkg::BYTE_W'($urandom), brr_pkg::LEN_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // result side: ready stalls drawn per transfer, each transfer checked
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        while (!rst_n) @(posedge clk);
        forever
        begin
            draw_gap(rsp_quiet, gap);
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            tracker.match_result(rsp);
        end
    end

    // ------------------------------------------------------------------
    // command side: reset, directed commands, random sequences, drain
    // ------------------------------------------------------------------
    initial
    begin
        int directed_count;
        int full_mark;
        int passes;
        bit filling;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reads of an empty buffer
        send_cmd(brr_pkg::FN_GET, 8'h00, 7'd1);
        send_cmd(brr_pkg::FN_SKIP, 8'hff, 7'd127);
        send_cmd(brr_pkg::FN_PEEK, 8'h00, 7'd0);
        // zero length append is a one byte run with invalid length
        send_cmd(brr_pkg::FN_APPEND, 8'hff, 7'd0);
        // three byte run, later length fields ignored
        send_cmd(brr_pkg::FN_APPEND, 8'h00, 7'd3);
        send_cmd(brr_pkg::FN_APPEND, 8'hff, 7'd127);
        send_cmd(brr_pkg::FN_APPEND, 8'ha5, 7'd0);
        send_cmd(brr_pkg::FN_PEEK, 8'h00, 7'd3);
        // refused reads: zero, past the fill level, past the longest run
        send_cmd(brr_pkg::FN_GET, 8'h00, 7'd0);
        send_cmd(brr_pkg::FN_GET, 8'h00, 7'd4);
        send_cmd(brr_pkg::FN_GET, 8'h00, 7'd65);
        // read in the middle of an append run
        send_cmd(brr_pkg::FN_APPEND, 8'h5a, 7'd2);
        send_cmd(brr_pkg::FN_GET, 8'h00, 7'd1);
        send_cmd(brr_pkg::FN_APPEND, 8'h3c, 7'd64);
        send_cmd(brr_pkg::FN_SKIP, 8'h00, 7'd1);
        send_cmd(brr_pkg::FN_PEEK, 8'h00, 7'd2);
        // spare codes do nothing
        send_cmd(FN_SPARE_LO, 8'h00, 7'd1);
        send_cmd(FN_SPARE_HI, 8'hff, 7'd127);
        // clear abandons a run in progress, next append starts fresh
        send_cmd(brr_pkg::FN_APPEND, 8'h77, 7'd4);
        send_cmd(brr_pkg::FN_APPEND, 8'h88, 7'd0);
        send_cmd(brr_pkg::FN_CLEAR, 8'h00, 7'd0);
        send_cmd(brr_pkg::FN_APPEND, 8'h01, 7'd1);
        send_cmd(brr_pkg::FN_GET, 8'h00, 7'd1);
        send_cmd(brr_pkg::FN_CLEAR, 8'hff, 7'd127);
        directed_count = commands_sent;

        // lean toward filling until a run is refused as full, then drain
        filling   = 1'b1;
        full_mark = tracker.status_hits[brr_pkg::STAT_FULL];
        passes    = 0;
        while (commands_sent - directed_count < RAND_ITEMS)
        begin
            random_step(filling);
            if (filling && int'(tracker.fill) >= brr_pkg::DEPTH - 8
                && tracker.status_hits[brr_pkg::STAT_FULL] > full_mark)
            begin
                filling = 1'b0;
            end
            else if (!filling && int'(tracker.fill) < brr_pkg::MAX_RUN)
            begin
                filling   = 1'b1;
                full_mark = tracker.status_hits[brr_pkg::STAT_FULL];
                passes++;
            end
        end
        req_valid <= 1'b0;

        // wait out the remaining results, then watch for strays
        while (tracker.pending_rsp.size() != 0) @(posedge clk);
        repeat (END_IDLE) @(posedge clk);

        $display("covered %0d commands, %0d results checked, %0d data bytes read back",
                 commands_sent, tracker.checked, tracker.bytes_seen);
        $display("refusals: %0d full, %0d invalid length, %0d empty; %0d fill and drain passes",
                 tracker.status_hits[brr_pkg::STAT_FULL],
                 tracker.status_hits[brr_pkg::STAT_BADLEN],
                 tracker.status_hits[brr_pkg::STAT_NODATA], passes);
        if (tracker.mismatches == 0 && tracker.pending_rsp.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
